// ===== rtl/core/mbp_pkg.sv =====
// Shared types, constants and codes of the multipart body parser.
package mbp_pkg;

    localparam int MAX_DELIMITER_DEF = 32;
    localparam int OFFSET_BITS_DEF   = 32;

    localparam int DELIM_BYTES = 32;
    localparam int DIDX_W      = $clog2(DELIM_BYTES);
    localparam int MIN_DELIM   = 3;

    localparam int CFG_LEN_W  = 6;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_DELIM_LEN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM_W0  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM_W1  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM_W2  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM_W3  = 3'd4;

    localparam int EV_W = 3;
    localparam logic [EV_W-1:0] EV_NONE      = 3'd0;
    localparam logic [EV_W-1:0] EV_HDR_BYTE  = 3'd1;
    localparam logic [EV_W-1:0] EV_LINE_DONE = 3'd2;
    localparam logic [EV_W-1:0] EV_PART_DONE = 3'd3;
    localparam logic [EV_W-1:0] EV_STOPPED   = 3'd4;

    localparam int PH_W = 3;
    localparam logic [PH_W-1:0] PH_SEEK     = 3'd0;
    localparam logic [PH_W-1:0] PH_END_CR   = 3'd1;
    localparam logic [PH_W-1:0] PH_END_LF   = 3'd2;
    localparam logic [PH_W-1:0] PH_HEADERS  = 3'd3;
    localparam logic [PH_W-1:0] PH_HDR_LF   = 3'd4;
    localparam logic [PH_W-1:0] PH_BLANK_LF = 3'd5;
    localparam logic [PH_W-1:0] PH_DATA     = 3'd6;
    localparam logic [PH_W-1:0] PH_STOPPED  = 3'd7;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam int SEARCH_W = 6;
    localparam logic [SEARCH_W-1:0] SEARCH_MAX = 6'd63;

    localparam int RES_OFS_W  = 32;
    localparam int OUT_DATA_W = 72;
    localparam int OUT_USER_W = 4;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic [EV_W-1:0]      ev_code;
        byte_t                header_char;
        logic                 in_value;
        logic [RES_OFS_W-1:0] data_start;
        logic [RES_OFS_W-1:0] data_end;
    } result_t;

endpackage

// ===== rtl/core/mbp_cell.sv =====
// One window cell: holds one recent byte and compares the byte entering it.
module mbp_cell
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          shift_en,
    input  mbp_pkg::byte_t left_byte,
    input  mbp_pkg::byte_t ref_byte,
    input  logic          in_use,
    output mbp_pkg::byte_t held_byte,
    output logic          hit
);
    import mbp_pkg::*;

    byte_t held_reg;
    byte_t held_next;

    // The compare looks at the byte this cell will hold after the shift.
    assign hit       = !in_use || (left_byte == ref_byte);
    assign held_next = shift_en ? left_byte : held_reg;
    assign held_byte = held_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else
        begin
            held_reg <= held_next;
        end
    end

endmodule

// ===== rtl/core/mbp_window.sv =====
// Row of window cells that shifts the body bytes and matches the delimiter.
module mbp_window
#(
    parameter int MAX_DELIMITER = mbp_pkg::MAX_DELIMITER_DEF
)
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     shift_en,
    input  mbp_pkg::byte_t                           new_byte,
    input  logic [mbp_pkg::CFG_LEN_W-1:0]            active_len,
    input  logic [mbp_pkg::DELIM_BYTES*8-1:0]        delim_flat,
    output logic                                     match
);
    import mbp_pkg::*;

    byte_t                    held [MAX_DELIMITER];
    logic [MAX_DELIMITER-1:0] hits;

    for (genvar k = 0; k < MAX_DELIMITER; k++)
    begin : g_cell
        byte_t                left_byte;
        byte_t                ref_byte;
        logic [CFG_LEN_W-1:0] ref_idx;
        logic                 in_use;

        if (k == 0)
        begin : g_head
            assign left_byte = new_byte;
        end
        else
        begin : g_body
            assign left_byte = held[k-1];
        end

        // Cell k holds the k-th newest byte, which lines up with delimiter
        // byte (length - 1 - k).
        assign ref_idx  = active_len - CFG_LEN_W'(1) - CFG_LEN_W'(k);
        assign in_use   = CFG_LEN_W'(k) < active_len;
        assign ref_byte = delim_flat[8*ref_idx[DIDX_W-1:0] +: 8];

        mbp_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift_en  (shift_en),
            .left_byte (left_byte),
            .ref_byte  (ref_byte),
            .in_use    (in_use),
            .held_byte (held[k]),
            .hit       (hits[k])
        );
    end

    assign match = &hits;

endmodule

// ===== rtl/core/multipart_body_parser_core.sv =====
// Top level of the multipart body parser: phase control, offsets and result register.
//
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tdata: body byte
// m_        out  m_tvalid/m_tready  m_tdata: header char, data start/end; m_tuser: event, in_value
// cfg_      in   cfg_we             cfg_index, cfg_wdata
//
// One body byte is taken per cycle while s_tready is high; its result item is registered and shown in the next cycle.
// The delimiter window compares all cells in parallel, so each byte is
// matched in the cycle it is accepted. A single output register holds the result;
// s_tready drops only while that register is full and m_tready is low.
// Reset clears the window, phase, offsets and delimiter words; the length resets to MIN_DELIM.
module multipart_body_parser_core
#(
    parameter int MAX_DELIMITER = mbp_pkg::MAX_DELIMITER_DEF,
    parameter int OFFSET_BITS   = mbp_pkg::OFFSET_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] body_byte
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] header_char, [39:8] data_start, [71:40] data_end
    output logic [mbp_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic [mbp_pkg::OUT_USER_W-1:0]      m_tuser,   // [2:0] event_res, [3] in_value
    input  logic                                cfg_we,
    input  logic [mbp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mbp_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import mbp_pkg::*;

    logic [CFG_LEN_W-1:0]  len_reg,   len_next;
    logic [CFG_DATA_W-1:0] word0_reg, word0_next;
    logic [CFG_DATA_W-1:0] word1_reg, word1_next;
    logic [CFG_DATA_W-1:0] word2_reg, word2_next;
    logic [CFG_DATA_W-1:0] word3_reg, word3_next;

    logic [PH_W-1:0]        phase_reg,  phase_next;
    logic [SEARCH_W-1:0]    search_reg, search_next;
    logic                   empty_reg,  empty_next;
    logic                   colon_reg,  colon_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [OFFSET_BITS-1:0] begin_reg,  begin_next;

    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg,   out_res_next;

    logic                   accept;
    logic [CFG_LEN_W-1:0]   active_len;
    logic                   match;
    logic                   seen;
    byte_t                  b;
    result_t                res;
    logic [OFFSET_BITS-1:0] end_ofs;

    assign b        = s_tdata;
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        active_len = len_reg;
        if (active_len < CFG_LEN_W'(MIN_DELIM))
        begin
            active_len = CFG_LEN_W'(MIN_DELIM);
        end
        if (active_len > CFG_LEN_W'(MAX_DELIMITER))
        begin
            active_len = CFG_LEN_W'(MAX_DELIMITER);
        end
    end

    // Configuration writes.
    always_comb
    begin
        len_next   = len_reg;
        word0_next = word0_reg;
        word1_next = word1_reg;
        word2_next = word2_reg;
        word3_next = word3_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DELIM_LEN: len_next   = cfg_wdata[CFG_LEN_W-1:0];
                CFG_DELIM_W0:  word0_next = cfg_wdata;
                CFG_DELIM_W1:  word1_next = cfg_wdata;
                CFG_DELIM_W2:  word2_next = cfg_wdata;
                CFG_DELIM_W3:  word3_next = cfg_wdata;
                default:       len_next   = len_reg;
            endcase
        end
    end

    mbp_window #(.MAX_DELIMITER(MAX_DELIMITER)) u_window
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .shift_en   (accept),
        .new_byte   (b),
        .active_len (active_len),
        .delim_flat ({word3_reg, word2_reg, word1_reg, word0_reg}),
        .match      (match)
    );

    // A match counts only when every delimiter byte came in during this search.
    assign seen    = match &&
                     (({1'b0, search_reg} + (SEARCH_W+1)'(1)) >= {1'b0, active_len});
    assign end_ofs = offset_reg - OFFSET_BITS'(active_len) - OFFSET_BITS'(1);

    always_comb
    begin
        phase_next  = phase_reg;
        search_next = search_reg;
        empty_next  = empty_reg;
        colon_next  = colon_reg;
        begin_next  = begin_reg;
        offset_next = offset_reg;
        res         = '0;
        res.ev_code = EV_NONE;

        if (accept)
        begin
            offset_next = offset_reg + OFFSET_BITS'(1);
            unique case (phase_reg)
                PH_SEEK, PH_DATA:
                begin
                    if (seen)
                    begin
                        if (phase_reg == PH_DATA)
                        begin
                            res.ev_code    = EV_PART_DONE;
                            res.data_start = RES_OFS_W'(begin_reg);
                            res.data_end   = RES_OFS_W'(end_ofs);
                        end
                        phase_next = PH_END_CR;
                    end
                    else if (search_reg < SEARCH_MAX)
                    begin
                        search_next = search_reg + SEARCH_W'(1);
                    end
                end
                PH_END_CR:
                begin
                    phase_next = (b == CH_CR) ? PH_END_LF : PH_STOPPED;
                end
                PH_END_LF:
                begin
                    if (b == CH_LF)
                    begin
                        phase_next = PH_HEADERS;
                        empty_next = 1'b1;
                        colon_next = 1'b0;
                    end
                    else
                    begin
                        phase_next = PH_STOPPED;
                    end
                end
                PH_HEADERS:
                begin
                    if (b == CH_CR)
                    begin
                        phase_next = empty_reg ? PH_BLANK_LF : PH_HDR_LF;
                    end
                    else
                    begin
                        res.ev_code     = EV_HDR_BYTE;
                        res.header_char = b;
                        res.in_value    = colon_reg;
                        if (b == CH_COLON)
                        begin
                            colon_next = 1'b1;
                        end
                        empty_next = 1'b0;
                    end
                end
                PH_HDR_LF:
                begin
                    if (b == CH_LF)
                    begin
                        res.ev_code = EV_LINE_DONE;
                        phase_next  = PH_HEADERS;
                        empty_next  = 1'b1;
                        colon_next  = 1'b0;
                    end
                    else
                    begin
                        phase_next = PH_STOPPED;
                    end
                end
                PH_BLANK_LF:
                begin
                    if (b == CH_LF)
                    begin
                        phase_next  = PH_DATA;
                        begin_next  = offset_reg + OFFSET_BITS'(1);
                        search_next = '0;
                    end
                    else
                    begin
                        phase_next = PH_STOPPED;
                    end
                end
                default:
                begin
                    phase_next = PH_STOPPED;
                end
            endcase

            if (phase_next == PH_STOPPED)
            begin
                res         = '0;
                res.ev_code = EV_STOPPED;
            end
        end
    end

    assign out_valid_next = accept || (out_valid_reg && !m_tready);
    assign out_res_next   = accept ? res : out_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= CFG_LEN_W'(MIN_DELIM);
            word0_reg     <= '0;
            word1_reg     <= '0;
            word2_reg     <= '0;
            word3_reg     <= '0;
            phase_reg     <= PH_SEEK;
            search_reg    <= '0;
            empty_reg     <= 1'b1;
            colon_reg     <= 1'b0;
            offset_reg    <= '0;
            begin_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            word0_reg     <= word0_next;
            word1_reg     <= word1_next;
            word2_reg     <= word2_next;
            word3_reg     <= word3_next;
            phase_reg     <= phase_next;
            search_reg    <= search_next;
            empty_reg     <= empty_next;
            colon_reg     <= colon_next;
            offset_reg    <= offset_next;
            begin_reg     <= begin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_res_reg.data_end, out_res_reg.data_start, out_res_reg.header_char};
    assign m_tuser  = {out_res_reg.in_value, out_res_reg.ev_code};

endmodule

// ===== rtl/core/mbp_checker.sv =====
// Port-level checks of the multipart body parser, bound to the top level.
module mbp_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [mbp_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [mbp_pkg::OUT_USER_W-1:0] m_tuser
);
    import mbp_pkg::*;

    logic            stop_seen_reg, stop_seen_next;
    logic [EV_W-1:0] ev;

    assign ev             = m_tuser[EV_W-1:0];
    assign stop_seen_next = stop_seen_reg || (m_tvalid && m_tready && (ev == EV_STOPPED));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_seen_reg <= 1'b0;
        end
        else
        begin
            stop_seen_reg <= stop_seen_next;
        end
    end

    // Once stopped, the block reports nothing else until reset.
    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && stop_seen_reg) |-> (ev == EV_STOPPED))
        else $error("item after stop is not a stop item");

    a_hdr_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (ev != EV_HDR_BYTE)) |-> ((m_tdata[7:0] == 8'h00) && !m_tuser[EV_W]))
        else $error("header fields set on a non-header item");

    a_ofs_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (ev != EV_PART_DONE)) |-> (m_tdata[OUT_DATA_W-1:8] == '0))
        else $error("offsets set on an item other than part done");

    // The single result register must not be overwritten while it waits.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !(s_tvalid && s_tready))
        else $error("input taken while result is stalled");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind multipart_body_parser_core mbp_checker u_mbp_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
